/* hdl/csm_pkg.sv */
// ----------------------------------------------------------------------------
// csm_pkg
// Shared widths, types and defaults for the sparse matrix-vector unit.
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int LANE_FIELDS = 4;
	localparam int COL_W       = 12;
	localparam int VAL_W       = 32;
	localparam int ACC_W       = 48;
	localparam int ROW_W       = 16;
	localparam int CNT_W       = 3;
	localparam int PAIR_W      = ACC_W + 1;
	localparam int GROUP_W     = ACC_W + 2;
	localparam int SUM_W       = ACC_W + 3;
	localparam int OFIFO_DEPTH = 16;

	localparam int DEF_VECTOR_DEPTH = 4096;
	localparam int DEF_LANES        = 4;

	// item kinds on req_type
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_GROUP = 1'b1;

	// per-lane control carried down the lane pipeline
	typedef struct packed {
		logic wr;
		logic act;
	} lane_ctl_t;

	// per-item control carried alongside the lane products
	typedef struct packed {
		logic valid;
		logic row_end;
		logic final_row;
	} row_ctl_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum;
		logic [ROW_W-1:0]        row;
		logic                    done;
	} result_t;

endpackage

/* hdl/csm_ram.sv */
// ----------------------------------------------------------------------------
// csm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/csm_lane.sv */
// ----------------------------------------------------------------------------
// csm_lane
// One multiply lane: column wrap, private copy of the vector store, and a
// registered Q16.16 x Q16.16 multiply reduced to Q32.16.
// ----------------------------------------------------------------------------
module csm_lane #(
	parameter int VECTOR_DEPTH = csm_pkg::DEF_VECTOR_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  csm_pkg::lane_ctl_t                 ctl,
	input  logic [csm_pkg::COL_W-1:0]          col,
	input  logic signed [csm_pkg::VAL_W-1:0]   val,
	output logic signed [csm_pkg::ACC_W-1:0]   prod
);

	localparam int AW       = $clog2(VECTOR_DEPTH);
	localparam int RECIP_SH = 24;
	localparam int RECIP    = (1 << RECIP_SH) / VECTOR_DEPTH;
	localparam int RW       = $clog2(RECIP + 1);
	localparam int MW       = csm_pkg::COL_W + RW;
	localparam int XW       = ((AW > csm_pkg::COL_W) ? AW : csm_pkg::COL_W) + 1;
	localparam int PW       = 2 * csm_pkg::VAL_W;

	logic [MW-1:0]                    qprod;
	logic [XW-1:0]                    rem0;
	logic [XW-1:0]                    rem1;
	logic signed [csm_pkg::VAL_W-1:0] xdata;
	logic signed [PW-1:0]             pfull;

	csm_pkg::lane_ctl_t               ctl_s1;
	csm_pkg::lane_ctl_t               ctl_s2;
	logic                             act_s3;
	logic [csm_pkg::COL_W-1:0]        col_s1;
	logic [csm_pkg::COL_W-1:0]        q_s1;
	logic signed [csm_pkg::VAL_W-1:0] val_s1;
	logic [AW-1:0]                    addr_s2;
	logic signed [csm_pkg::VAL_W-1:0] val_s2;
	logic signed [csm_pkg::VAL_W-1:0] val_s3;

	// quotient estimate by reciprocal; low by at most one
	assign qprod = MW'(col) * MW'(RECIP);
	assign rem0  = XW'(col_s1) - XW'(q_s1 * VECTOR_DEPTH);
	assign rem1  = (rem0 >= XW'(VECTOR_DEPTH)) ? rem0 - XW'(VECTOR_DEPTH) : rem0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			act_s3 <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			act_s3 <= ctl_s2.act;
		end
	end

	always_ff @(posedge clk) begin
		col_s1  <= col;
		q_s1    <= csm_pkg::COL_W'(qprod >> RECIP_SH);
		val_s1  <= val;
		addr_s2 <= rem1[AW-1:0];
		val_s2  <= val_s1;
		val_s3  <= val_s2;
	end

	csm_ram #(
		.WIDTH(csm_pkg::VAL_W),
		.DEPTH(VECTOR_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl_s2.wr),
		.waddr(addr_s2),
		.wdata(val_s2),
		.raddr(addr_s2),
		.rdata(xdata)
	);

	assign pfull = val_s3 * xdata;

	// Q32.32 to Q32.16 by dropping the low 16 bits
	always_ff @(posedge clk) begin
		prod <= act_s3 ? pfull[PW-1:PW-csm_pkg::ACC_W] : '0;
	end

endmodule

/* hdl/csm_merge.sv */
// ----------------------------------------------------------------------------
// csm_merge
// Registered adder tree over the lane products, saturating row accumulator
// and row counter.
// ----------------------------------------------------------------------------
module csm_merge #(
	parameter int NL = csm_pkg::DEF_LANES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  csm_pkg::row_ctl_t                ctl,
	input  logic signed [csm_pkg::ACC_W-1:0] prod [NL],
	output logic                             res_valid,
	output csm_pkg::result_t                 res
);

	localparam int AW = csm_pkg::ACC_W;
	localparam int SW = csm_pkg::SUM_W;

	logic signed [AW-1:0]                  pad [csm_pkg::LANE_FIELDS];
	logic signed [csm_pkg::PAIR_W-1:0]     pair_s5 [2];
	logic signed [csm_pkg::GROUP_W-1:0]    group_s6;
	csm_pkg::row_ctl_t                     ctl_s5;
	csm_pkg::row_ctl_t                     ctl_s6;

	logic signed [AW-1:0]                  acc_q;
	logic [csm_pkg::ROW_W-1:0]             row_q;
	logic signed [SW-1:0]                  sum;
	logic                                  fits;
	logic signed [AW-1:0]                  sat;

	genvar g;
	generate
		for (g = 0; g < csm_pkg::LANE_FIELDS; g++) begin : g_pad
			if (g < NL) begin : g_used
				assign pad[g] = prod[g];
			end else begin : g_zero
				assign pad[g] = '0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s5 <= ctl;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		pair_s5[0] <= csm_pkg::PAIR_W'(pad[0]) + csm_pkg::PAIR_W'(pad[1]);
		pair_s5[1] <= csm_pkg::PAIR_W'(pad[2]) + csm_pkg::PAIR_W'(pad[3]);
		group_s6   <= csm_pkg::GROUP_W'(pair_s5[0]) + csm_pkg::GROUP_W'(pair_s5[1]);
	end

	assign sum  = SW'(acc_q) + SW'(group_s6);
	assign fits = (sum[SW-1:AW-1] == '0) || (sum[SW-1:AW-1] == '1);
	assign sat  = fits ? sum[AW-1:0] :
		(sum[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			row_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= ctl_s6.valid && ctl_s6.row_end;
			if (ctl_s6.valid) begin
				if (ctl_s6.row_end) begin
					acc_q <= '0;
					row_q <= ctl_s6.final_row ? '0 : row_q + 1'b1;
				end else begin
					acc_q <= sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s6.valid && ctl_s6.row_end) begin
			res.sum  <= sat;
			res.row  <= row_q;
			res.done <= ctl_s6.final_row;
		end
	end

endmodule

/* hdl/csr_sparse_matvec.sv */
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// Sparse matrix times dense vector over compressed rows, fixed point.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle, loads and compute groups alike. Each
// multiply lane has its own copy of the vector store with one read port, so
// all lanes read in the same cycle, and a load writes every copy at once.
// A row sum passes the lane, adder-tree and result registers into the
// output queue; the only feedback on sums is the row accumulator's
// add-and-saturate. Results wait in a 16-entry output queue; item_ready
// drops only when queued results plus rows still in flight would fill it.
// ----------------------------------------------------------------------------
module csr_sparse_matvec #(
	parameter int VECTOR_DEPTH = csm_pkg::DEF_VECTOR_DEPTH,
	parameter int LANES        = csm_pkg::DEF_LANES
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             req_type,
	input  logic [csm_pkg::COL_W-1:0]        col_a,
	input  logic [csm_pkg::COL_W-1:0]        col_b,
	input  logic [csm_pkg::COL_W-1:0]        col_c,
	input  logic [csm_pkg::COL_W-1:0]        col_d,
	input  logic signed [csm_pkg::VAL_W-1:0] val_a,
	input  logic signed [csm_pkg::VAL_W-1:0] val_b,
	input  logic signed [csm_pkg::VAL_W-1:0] val_c,
	input  logic signed [csm_pkg::VAL_W-1:0] val_d,
	input  logic [csm_pkg::CNT_W-1:0]        lane_count,
	input  logic                             row_end,
	input  logic                             final_row,

	output logic                             result_valid,
	input  logic                             result_ready,
	output logic signed [csm_pkg::ACC_W-1:0] row_sum,
	output logic [csm_pkg::ROW_W-1:0]        row_number,
	output logic                             matrix_done
);

	localparam int NL    = (LANES < csm_pkg::LANE_FIELDS) ? LANES : csm_pkg::LANE_FIELDS;
	localparam int DEPTH = csm_pkg::OFIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic                             fire;
	logic                             is_load;
	logic [csm_pkg::CNT_W-1:0]        cnt_clip;
	logic [csm_pkg::COL_W-1:0]        col_in  [csm_pkg::LANE_FIELDS];
	logic signed [csm_pkg::VAL_W-1:0] val_in  [csm_pkg::LANE_FIELDS];
	logic signed [csm_pkg::ACC_W-1:0] prod    [NL];

	csm_pkg::row_ctl_t                ctl_in;
	csm_pkg::row_ctl_t                ctl_s1;
	csm_pkg::row_ctl_t                ctl_s2;
	csm_pkg::row_ctl_t                ctl_s3;
	csm_pkg::row_ctl_t                ctl_s4;

	logic                             res_valid;
	csm_pkg::result_t                 res;

	csm_pkg::result_t                 fifo_q [DEPTH];
	logic [PTR_W-1:0]                 wr_ptr_q;
	logic [PTR_W-1:0]                 rd_ptr_q;
	logic [CW-1:0]                    cnt_q;
	logic [CW-1:0]                    pend_q;
	logic                             pop;
	logic                             open_row;

	assign fire     = item_valid && item_ready;
	assign is_load  = (req_type == csm_pkg::REQ_LOAD);
	assign cnt_clip = (lane_count > csm_pkg::CNT_W'(NL)) ? csm_pkg::CNT_W'(NL) : lane_count;
	assign open_row = fire && !is_load && row_end;

	// a load steers lane a's index and element into every lane
	assign col_in[0] = col_a;
	assign col_in[1] = is_load ? col_a : col_b;
	assign col_in[2] = is_load ? col_a : col_c;
	assign col_in[3] = is_load ? col_a : col_d;
	assign val_in[0] = val_a;
	assign val_in[1] = is_load ? val_a : val_b;
	assign val_in[2] = is_load ? val_a : val_c;
	assign val_in[3] = is_load ? val_a : val_d;

	genvar g;
	generate
		for (g = 0; g < NL; g++) begin : g_lane
			csm_pkg::lane_ctl_t lctl;

			assign lctl.wr  = fire && is_load;
			assign lctl.act = fire && !is_load && (csm_pkg::CNT_W'(g) < cnt_clip);

			csm_lane #(
				.VECTOR_DEPTH(VECTOR_DEPTH)
			) u_lane (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (lctl),
				.col   (col_in[g]),
				.val   (val_in[g]),
				.prod  (prod[g])
			);
		end
	endgenerate

	assign ctl_in.valid     = fire && !is_load;
	assign ctl_in.row_end   = row_end;
	assign ctl_in.final_row = final_row;

	// item control matched to the lane latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	csm_merge #(
		.NL(NL)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_s4),
		.prod     (prod),
		.res_valid(res_valid),
		.res      (res)
	);

	// output queue; credits cover every row still in the pipeline
	assign pop          = result_valid && result_ready;
	assign result_valid = (cnt_q != '0);
	assign item_ready   = ((CW + 1)'(pend_q) + (CW + 1)'(cnt_q)) < (CW + 1)'(DEPTH);
	assign row_sum      = fifo_q[rd_ptr_q].sum;
	assign row_number   = fifo_q[rd_ptr_q].row;
	assign matrix_done  = fifo_q[rd_ptr_q].done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q  <= cnt_q + CW'(res_valid) - CW'(pop);
			pend_q <= pend_q + CW'(open_row) - CW'(res_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cnt_q < CW'(DEPTH)) || pop)
		else $error("result written into a full output queue");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((CW + 1)'(pend_q) + (CW + 1)'(cnt_q)) <= (CW + 1)'(DEPTH))
		else $error("rows in flight exceed output queue space");

	a_result_expected: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (pend_q != '0))
		else $error("row result with no closing item in flight");

endmodule
